// ===== rtl/bmc_pkg.sv =====
package bmc_pkg;

  localparam int GRID_W      = 32;
  localparam int GRID_H      = 16;
  localparam int STACK_DEPTH = 128;

  localparam int X_W      = $clog2(GRID_W);
  localparam int Y_W      = $clog2(GRID_H);
  localparam int MAP_AW   = X_W + Y_W;
  localparam int MAP_SIZE = GRID_W * GRID_H;
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int CNT_W    = 8;
  localparam int MS_W     = 32;
  localparam int CFG_W    = 16;
  localparam int RND_W    = 32;
  localparam int ACT_W    = 3;
  localparam int NIB_W    = 4;
  localparam int MOD_STEPS = RND_W / NIB_W;
  localparam int MODC_W   = $clog2(MOD_STEPS + 1);

  localparam logic [ACT_W-1:0] ACT_INIT      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_THROTTLED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CARVED    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BACKTRACK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_WAITING   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESTART   = 3'd5;

  localparam logic REG_FRAME_INTERVAL = 1'b0;
  localparam logic REG_RESTART_HOLD   = 1'b1;

  // Directions in probe order.
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XN = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YN = 2'd3;

  typedef struct packed {
    logic [MS_W-1:0]  now_ms;
    logic [RND_W-1:0] random_value;
    logic             force_restart;
    logic [X_W-1:0]   query_x;
    logic [Y_W-1:0]   query_y;
  } in_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [X_W-1:0]   head_x;
    logic [Y_W-1:0]   head_y;
    logic [CNT_W-1:0] stack_depth;
    logic [X_W-1:0]   carved_x;
    logic [Y_W-1:0]   carved_y;
    logic             query_open;
  } out_t;

  // One residue step of a modulo-3 reduction: 16 is 1 mod 3, so each nibble
  // simply adds to the running residue.
  function automatic logic [1:0] mod3_add(input logic [1:0] r, input logic [NIB_W-1:0] d);
    logic [4:0] v;
    v = {3'b000, r} + {1'b0, d};
    if (v >= 5'd12) v = v - 5'd12;
    if (v >= 5'd6)  v = v - 5'd6;
    if (v >= 5'd3)  v = v - 5'd3;
    return v[1:0];
  endfunction

  function automatic logic [2:0] count_set(input logic [3:0] m);
    return {2'b00, m[0]} + {2'b00, m[1]} + {2'b00, m[2]} + {2'b00, m[3]};
  endfunction

  // Returns the direction of the k-th set bit of the mask.
  function automatic logic [1:0] pick_dir(input logic [3:0] m, input logic [1:0] k);
    logic [1:0] seen;
    logic [1:0] dir;
    logic       found;
    seen  = 2'd0;
    dir   = DIR_XP;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        if (!found && seen == k) begin
          dir   = i[1:0];
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    return dir;
  endfunction

endpackage

// ===== rtl/backtracking_maze_carver.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data  (in_t)
// out       output     out_valid / out_ready   out_data (out_t)
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One item is handled at a time; in_ready is high only while the sequencer is idle.
// A throttled item passes through the query read and wait states to S_DONE; a waiting or
// restart item goes through S_HOLD first. A carving or backtracking step probes, then waits
// in S_DECIDE for the nibble-serial modulo-3 unit, which outlasts the four neighbour probes
// through the single read port of the grid memory; it then carves or pops (a pop that empties
// the stack skips the stack read) before the query read. Apart from an initialising item,
// in_ready returns on the cycle after the result is loaded. An initialising item goes straight
// to S_DONE and is then followed by a clearing pass over all 512 cells before the next transfer.
// Reset is synchronous; the grid needs no pass after reset, as the first item
// always initialises. A stalled result waits in the output register.
module backtracking_maze_carver
  import bmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE       = 12'b0000_0000_0001,
    S_PROBE      = 12'b0000_0000_0010,
    S_DECIDE     = 12'b0000_0000_0100,
    S_CARVE_MID  = 12'b0000_0000_1000,
    S_CARVE_TGT  = 12'b0000_0001_0000,
    S_POP_RD     = 12'b0000_0010_0000,
    S_POP_WAIT   = 12'b0000_0100_0000,
    S_HOLD       = 12'b0000_1000_0000,
    S_QUERY_RD   = 12'b0001_0000_0000,
    S_QUERY_WAIT = 12'b0010_0000_0000,
    S_DONE       = 12'b0100_0000_0000,
    S_SWEEP      = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic             open_mem [MAP_SIZE];
  logic [MAP_AW-1:0] map_raddr;
  logic              map_rdata;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic              map_wdata;

  logic [X_W+Y_W-1:0] stack_mem [STACK_DEPTH];
  logic [STK_AW-1:0]  stk_raddr;
  logic [X_W+Y_W-1:0] stk_rdata;
  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr;
  logic [X_W+Y_W-1:0] stk_wdata;

  in_t              item;
  logic             initialized;
  logic [MS_W-1:0]  last_ms;
  logic [MS_W-1:0]  complete_ms;
  logic [CFG_W-1:0] frame_ms;
  logic [CFG_W-1:0] hold_ms;
  logic [CNT_W-1:0] stack_count;
  logic [X_W-1:0]   head_x;
  logic [Y_W-1:0]   head_y;
  logic [ACT_W-1:0] res_action;
  logic [X_W-1:0]   carved_x;
  logic [Y_W-1:0]   carved_y;
  logic             query_open;
  logic [2:0]       probe_idx;
  logic [3:0]       valid_mask;
  logic [RND_W-1:0] mod_sh;
  logic [1:0]       mod_r;
  logic [MODC_W-1:0] mod_cnt;
  logic [MAP_AW-1:0] sweep_cnt;
  logic [X_W-1:0]   mid_x;
  logic [Y_W-1:0]   mid_y;
  logic [X_W-1:0]   tgt_x;
  logic [Y_W-1:0]   tgt_y;

  logic             accept;
  logic [MS_W-1:0]  since_step;
  logic [MS_W-1:0]  complete_eff;
  logic [MS_W-1:0]  since_done;
  logic [3:0]       in_bounds;
  logic [1:0]       probe_dir;
  logic [X_W-1:0]   nb_x;
  logic [Y_W-1:0]   nb_y;
  logic [2:0]       valid_cnt;
  logic [1:0]       pick_k;
  logic [1:0]       dir;
  logic [CNT_W-1:0] count_dec;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign since_step = in_data.now_ms - last_ms;
  assign complete_eff = (complete_ms == '0) ? item.now_ms : complete_ms;
  assign since_done = item.now_ms - complete_eff;
  assign count_dec  = stack_count - CNT_W'(1);

  // A neighbour two cells away stays strictly inside the border.
  assign in_bounds[DIR_XP] = head_x < X_W'(GRID_W - 3);
  assign in_bounds[DIR_XN] = head_x > X_W'(2);
  assign in_bounds[DIR_YP] = head_y < Y_W'(GRID_H - 3);
  assign in_bounds[DIR_YN] = head_y > Y_W'(2);

  assign probe_dir = probe_idx[1:0];

  always_comb begin
    nb_x = head_x;
    nb_y = head_y;
    case (probe_dir)
      DIR_XP:  nb_x = head_x + X_W'(2);
      DIR_XN:  nb_x = head_x - X_W'(2);
      DIR_YP:  nb_y = head_y + Y_W'(2);
      DIR_YN:  nb_y = head_y - Y_W'(2);
      default: nb_x = head_x;
    endcase
  end

  assign valid_cnt = count_set(valid_mask);

  always_comb begin
    case (valid_cnt)
      3'd2:    pick_k = {1'b0, item.random_value[0]};
      3'd3:    pick_k = mod_r;
      3'd4:    pick_k = item.random_value[1:0];
      default: pick_k = 2'd0;
    endcase
  end

  assign dir = pick_dir(valid_mask, pick_k);

  // Grid memory port control.
  always_comb begin
    map_raddr = {item.query_x, item.query_y};
    map_we    = 1'b0;
    map_waddr = {mid_x, mid_y};
    map_wdata = 1'b1;
    case (state)
      S_PROBE: begin
        map_raddr = {nb_x, nb_y};
      end
      S_CARVE_MID: begin
        map_we = 1'b1;
      end
      S_CARVE_TGT: begin
        map_we    = 1'b1;
        map_waddr = {tgt_x, tgt_y};
      end
      S_SWEEP: begin
        map_we    = 1'b1;
        map_waddr = sweep_cnt;
        map_wdata = (sweep_cnt == {X_W'(1), Y_W'(1)});
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  // Stack memory port control.
  always_comb begin
    stk_raddr = count_dec[STK_AW-1:0];
    stk_we    = 1'b0;
    stk_waddr = stack_count[STK_AW-1:0];
    stk_wdata = {tgt_x, tgt_y};
    if (accept && (in_data.force_restart || !initialized)) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {X_W'(1), Y_W'(1)};
    end else if (state == S_CARVE_TGT) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      open_mem[map_waddr] <= map_wdata;
    end
    map_rdata <= open_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stack_mem[stk_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ms <= CFG_W'(20);
      hold_ms  <= CFG_W'(3000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_INTERVAL: frame_ms <= cfg_data;
        REG_RESTART_HOLD:   hold_ms  <= cfg_data;
        default:            frame_ms <= frame_ms;
      endcase
    end
  end

  // Nibble-serial residue of the random word modulo three.
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= MODC_W'(MOD_STEPS);
    end else if (accept) begin
      mod_sh  <= in_data.random_value;
      mod_r   <= 2'd0;
      mod_cnt <= '0;
    end else if (mod_cnt != MODC_W'(MOD_STEPS)) begin
      mod_r   <= mod3_add(mod_r, mod_sh[NIB_W-1:0]);
      mod_sh  <= mod_sh >> NIB_W;
      mod_cnt <= mod_cnt + MODC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initialized <= 1'b0;
      last_ms     <= '0;
      complete_ms <= '0;
      stack_count <= CNT_W'(1);
      head_x      <= X_W'(1);
      head_y      <= Y_W'(1);
      out_valid   <= 1'b0;
      probe_idx   <= '0;
      sweep_cnt   <= '0;
    end else begin
      // In S_DONE the output register is reloaded instead, so it is left alone here.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item     <= in_data;
            carved_x <= '0;
            carved_y <= '0;
            if (in_data.force_restart || !initialized) begin
              initialized <= 1'b1;
              last_ms     <= in_data.now_ms;
              complete_ms <= '0;
              stack_count <= CNT_W'(1);
              head_x      <= X_W'(1);
              head_y      <= Y_W'(1);
              res_action  <= ACT_INIT;
              // After initialising only cell (1,1) is open.
              query_open  <= (in_data.query_x == X_W'(1)) && (in_data.query_y == Y_W'(1));
              state       <= S_DONE;
            end else if (since_step < {{(MS_W-CFG_W){1'b0}}, frame_ms}) begin
              res_action <= ACT_THROTTLED;
              state      <= S_QUERY_RD;
            end else begin
              last_ms <= in_data.now_ms;
              if (stack_count != '0) begin
                probe_idx  <= '0;
                valid_mask <= '0;
                state      <= S_PROBE;
              end else begin
                state <= S_HOLD;
              end
            end
          end
        end
        S_PROBE: begin
          // Read data for the previous probe arrives in the cycle after its address.
          if (probe_idx != '0) begin
            valid_mask[probe_idx[1:0] - 2'd1] <= in_bounds[probe_idx[1:0] - 2'd1] && !map_rdata;
          end
          if (probe_idx == 3'd4) begin
            state <= S_DECIDE;
          end else begin
            probe_idx <= probe_idx + 3'd1;
          end
        end
        S_DECIDE: begin
          if (mod_cnt == MODC_W'(MOD_STEPS)) begin
            if (valid_cnt != 3'd0 && stack_count < CNT_W'(STACK_DEPTH)) begin
              mid_x <= head_x;
              mid_y <= head_y;
              tgt_x <= head_x;
              tgt_y <= head_y;
              case (dir)
                DIR_XP: begin
                  mid_x <= head_x + X_W'(1);
                  tgt_x <= head_x + X_W'(2);
                end
                DIR_XN: begin
                  mid_x <= head_x - X_W'(1);
                  tgt_x <= head_x - X_W'(2);
                end
                DIR_YP: begin
                  mid_y <= head_y + Y_W'(1);
                  tgt_y <= head_y + Y_W'(2);
                end
                DIR_YN: begin
                  mid_y <= head_y - Y_W'(1);
                  tgt_y <= head_y - Y_W'(2);
                end
                default: begin
                  mid_x <= head_x;
                end
              endcase
              res_action <= ACT_CARVED;
              state      <= S_CARVE_MID;
            end else begin
              res_action  <= ACT_BACKTRACK;
              stack_count <= count_dec;
              if (count_dec != '0) begin
                state <= S_POP_RD;
              end else begin
                head_x <= '0;
                head_y <= '0;
                state  <= S_QUERY_RD;
              end
            end
          end
        end
        S_CARVE_MID: begin
          state <= S_CARVE_TGT;
        end
        S_CARVE_TGT: begin
          stack_count <= stack_count + CNT_W'(1);
          head_x      <= tgt_x;
          head_y      <= tgt_y;
          carved_x    <= tgt_x;
          carved_y    <= tgt_y;
          state       <= S_QUERY_RD;
        end
        S_POP_RD: begin
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          head_x <= stk_rdata[X_W+Y_W-1:Y_W];
          head_y <= stk_rdata[Y_W-1:0];
          state  <= S_QUERY_RD;
        end
        S_HOLD: begin
          if (since_done > {{(MS_W-CFG_W){1'b0}}, hold_ms}) begin
            complete_ms <= '0;
            initialized <= 1'b0;
            res_action  <= ACT_RESTART;
          end else begin
            complete_ms <= complete_eff;
            res_action  <= ACT_WAITING;
          end
          state <= S_QUERY_RD;
        end
        S_QUERY_RD: begin
          state <= S_QUERY_WAIT;
        end
        S_QUERY_WAIT: begin
          query_open <= map_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.action      <= res_action;
            out_data.head_x      <= head_x;
            out_data.head_y      <= head_y;
            out_data.stack_depth <= stack_count;
            out_data.carved_x    <= carved_x;
            out_data.carved_y    <= carved_y;
            out_data.query_open  <= query_open;
            sweep_cnt            <= '0;
            state <= (res_action == ACT_INIT) ? S_SWEEP : S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + MAP_AW'(1);
          if (sweep_cnt == MAP_AW'(MAP_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("item accepted while another was in progress");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_CARVE_TGT) |-> (stack_count < CNT_W'(STACK_DEPTH)))
    else $error("push onto a full stack");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && sweep_cnt == MAP_AW'(MAP_SIZE - 1)) |=> (state == S_IDLE))
    else $error("clearing pass did not finish");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("result not presented");

endmodule

// ===== sim/backtracking_maze_carver_test.sv =====
`timescale 1ns / 1ps

module backtracking_maze_carver_test;
  import bmc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  // Covers a result still in flight plus the clearing pass after an initialising item.
  localparam int SETTLE_CYCLES = 600;
  localparam int PHASE_ITEMS   = 140;
  localparam int PROBE_COUNT   = 15;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } probe_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_FRAME_INTERVAL;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Local copy of the carver state.
  bit             grid_open [GRID_W][GRID_H];
  logic [X_W-1:0] trail_x [STACK_DEPTH];
  logic [Y_W-1:0] trail_y [STACK_DEPTH];
  int             trail_len    = 1;
  logic [31:0]    last_step_ms = '0;
  logic [31:0]    done_at_ms   = '0;
  bit             maze_started = 1'b0;
  logic [15:0]    frame_gap    = 16'd20;
  logic [15:0]    hold_span    = 16'd3000;

  out_t        reports_due [$];
  out_t        awaited;
  probe_t      probes [PROBE_COUNT];
  logic [31:0] clock_ms     = '0;
  bit          rough_maze   = 1'b0;
  bit          steady       = 1'b0;
  bit          held_off     = 1'b0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;

  backtracking_maze_carver u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_t advance_maze(input in_t item);
    out_t        res;
    logic [31:0] elapsed;
    int          hx;
    int          hy;
    int          nx;
    int          ny;
    int          tx;
    int          ty;
    int unsigned open_dirs;
    int unsigned pick;
    int          tgt_x [4];
    int          tgt_y [4];
    res = '0;
    if (item.force_restart) maze_started = 1'b0;
    elapsed = item.now_ms - last_step_ms;
    if (!maze_started) begin
      for (int gx = 0; gx < GRID_W; gx++) begin
        for (int gy = 0; gy < GRID_H; gy++) grid_open[gx][gy] = 1'b0;
      end
      grid_open[1][1] = 1'b1;
      trail_x[0]   = X_W'(1);
      trail_y[0]   = Y_W'(1);
      trail_len    = 1;
      done_at_ms   = '0;
      maze_started = 1'b1;
      last_step_ms = item.now_ms;
      res.action   = ACT_INIT;
    end else if (elapsed < 32'(frame_gap)) begin
      res.action = ACT_THROTTLED;
    end else begin
      last_step_ms = item.now_ms;
      if (trail_len > 0) begin
        hx = int'(trail_x[trail_len-1]);
        hy = int'(trail_y[trail_len-1]);
        open_dirs = 0;
        for (int d = 0; d < 4; d++) begin
          nx = hx;
          ny = hy;
          case (2'(d))
            DIR_XP:  nx = hx + 2;
            DIR_XN:  nx = hx - 2;
            DIR_YP:  ny = hy + 2;
            default: ny = hy - 2;
          endcase
          if (nx > 0 && nx < GRID_W - 1 && ny > 0 && ny < GRID_H - 1 && !grid_open[nx][ny]) begin
            tgt_x[open_dirs] = nx;
            tgt_y[open_dirs] = ny;
            open_dirs++;
          end
        end
        if (open_dirs > 0 && trail_len < STACK_DEPTH) begin
          pick = item.random_value % open_dirs;
          tx = tgt_x[pick];
          ty = tgt_y[pick];
          grid_open[(hx + tx) / 2][(hy + ty) / 2] = 1'b1;
          grid_open[tx][ty] = 1'b1;
          trail_x[trail_len] = X_W'(tx);
          trail_y[trail_len] = Y_W'(ty);
          trail_len++;
          res.action   = ACT_CARVED;
          res.carved_x = X_W'(tx);
          res.carved_y = Y_W'(ty);
        end else begin
          trail_len--;
          res.action = ACT_BACKTRACK;
        end
      end else begin
        // A completion stamped at time zero reads as unset and is stamped again.
        if (done_at_ms == 0) done_at_ms = item.now_ms;
        if (item.now_ms - done_at_ms > 32'(hold_span)) begin
          done_at_ms   = '0;
          maze_started = 1'b0;
          res.action   = ACT_RESTART;
        end else begin
          res.action = ACT_WAITING;
        end
      end
    end
    if (trail_len > 0) begin
      res.head_x = trail_x[trail_len-1];
      res.head_y = trail_y[trail_len-1];
    end
    res.stack_depth = CNT_W'(trail_len);
    res.query_open  = grid_open[item.query_x][item.query_y];
    return res;
  endfunction

  function automatic out_t outcome(input logic [ACT_W-1:0] act, input int hx, hy, depth, cx, cy,
                                   input int q);
    outcome = '{act, X_W'(hx), Y_W'(hy), CNT_W'(depth), X_W'(cx), Y_W'(cy), 1'(q)};
  endfunction

  function automatic probe_t probe(input logic [31:0] now, rnd, input bit restart_req,
                                   input int qx, qy, input bit typed, input out_t want);
    probe.item  = '{now, rnd, restart_req, X_W'(qx), Y_W'(qy)};
    probe.typed = typed;
    probe.want  = want;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    mismatches++;
    $display("MISMATCH at result %0d, %s: got %0h, expected %0h", results_seen, what, got,
             want);
  endtask

  task automatic match_field(input string what, input logic [31:0] got, want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic maybe_pause();
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Holds the item until the transfer, then books what the carver should report for it.
  task automatic offer_item(input in_t item, input logic typed, input out_t want);
    out_t forecast;
    in_data  = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forecast = advance_maze(item);
    clock_ms = item.now_ms;
    if (forecast.action == ACT_INIT) rough_maze = ($urandom_range(0, 3) == 0);
    reports_due.push_back(typed ? want : forecast);
    @(negedge clk);
  endtask

  task automatic drain_and_rest();
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_setting(input logic index, input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == REG_FRAME_INTERVAL) frame_gap = value;
    else hold_span = value;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("result with nothing awaited, action", 32'(out_data.action), '0);
      end else begin
        awaited = reports_due.pop_front();
        match_field("action", 32'(out_data.action), 32'(awaited.action));
        match_field("head_x", 32'(out_data.head_x), 32'(awaited.head_x));
        match_field("head_y", 32'(out_data.head_y), 32'(awaited.head_y));
        match_field("stack_depth", 32'(out_data.stack_depth), 32'(awaited.stack_depth));
        match_field("carved_x", 32'(out_data.carved_x), 32'(awaited.carved_x));
        match_field("carved_y", 32'(out_data.carved_y), 32'(awaited.carved_y));
        match_field("query_open", 32'(out_data.query_open), 32'(awaited.query_open));
      end
      results_seen++;
    end
  end

  // Receiver side; the single long hold-off lets the output register fill and back up the input.
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 60) begin
        held_off  = 1'b1;
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ready = steady || ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    in_t              item;
    int               roll;
    int               random_count;
    logic [CFG_W-1:0] new_frame;
    logic [CFG_W-1:0] new_hold;
    random_count = 0;
    trail_x[0] = X_W'(1);
    trail_y[0] = Y_W'(1);

    probes[0]  = probe(32'd100, 32'd0, 1'b0, 1, 1, 1'b1, outcome(ACT_INIT, 1, 1, 1, 0, 0, 1));
    probes[1]  = probe(32'd110, 32'd0, 1'b0, 3, 1, 1'b1,
                       outcome(ACT_THROTTLED, 1, 1, 1, 0, 0, 0));
    probes[2]  = probe(32'd120, 32'd0, 1'b0, 2, 1, 1'b1, outcome(ACT_CARVED, 3, 1, 2, 3, 1, 1));
    probes[3]  = probe(32'd139, 32'hFFFF_FFFF, 1'b0, 31, 15, 1'b1,
                       outcome(ACT_THROTTLED, 3, 1, 2, 0, 0, 0));
    probes[4]  = probe(32'd140, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, '0);
    // The clock wraps between these two steps.
    probes[5]  = probe(32'hFFFF_FFF0, 32'h8000_0000, 1'b0, 31, 0, 1'b0, '0);
    probes[6]  = probe(32'h0000_000A, 32'h5555_5555, 1'b0, 0, 15, 1'b0, '0);
    probes[7]  = probe(32'h0000_001D, 32'd3, 1'b0, 3, 3, 1'b0, '0);
    probes[8]  = probe(32'h0000_001E, 32'd3, 1'b0, 3, 2, 1'b0, '0);
    probes[9]  = probe(32'h0000_0032, 32'd2, 1'b0, 5, 5, 1'b0, '0);
    probes[10] = probe(32'd0, 32'd0, 1'b1, 1, 1, 1'b1, outcome(ACT_INIT, 1, 1, 1, 0, 0, 1));
    probes[11] = probe(32'd0, 32'd0, 1'b0, 3, 1, 1'b1,
                       outcome(ACT_THROTTLED, 1, 1, 1, 0, 0, 0));
    probes[12] = probe(32'd20, 32'd1, 1'b0, 1, 2, 1'b0, '0);
    probes[13] = probe(32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0, 16, 8, 1'b0, '0);
    probes[14] = probe(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 31, 15, 1'b1,
                       outcome(ACT_INIT, 1, 1, 1, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < PROBE_COUNT; r++) begin
      maybe_pause();
      offer_item(probes[r].item, probes[r].typed, probes[r].want);
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain_and_rest();
      case (phase)
        0: begin
          new_frame = '0;
          new_hold  = '0;
        end
        1: begin
          new_frame = '1;
          new_hold  = '1;
        end
        2: begin
          new_frame = CFG_W'($urandom_range(1, 40));
          new_hold  = CFG_W'($urandom_range(0, 4000));
        end
        3: begin
          new_frame = CFG_W'(1);
          new_hold  = CFG_W'(1);
        end
        default: begin
          new_frame = CFG_W'($urandom_range(0, 65535));
          new_hold  = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      write_setting(REG_FRAME_INTERVAL, new_frame);
      write_setting(REG_RESTART_HOLD, new_hold);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        steady = (random_count >= 300 && random_count < 450);
        item.random_value  = $urandom;
        item.query_x       = X_W'($urandom_range(0, GRID_W - 1));
        item.query_y       = Y_W'($urandom_range(0, GRID_H - 1));
        item.force_restart = 1'b0;
        roll = $urandom_range(0, 99);
        if (trail_len == 0) begin
          // Finished maze: stamp completion at time zero now and then, restart now and then.
          if (roll < 10) item.force_restart = 1'b1;
          if (roll >= 10 && roll < 35)
            item.now_ms = '0;
          else
            item.now_ms = clock_ms + 32'(frame_gap)
                          + $urandom_range(0, 32'(hold_span) * 3 / 2 + 1);
        end else begin
          if (rough_maze && roll < 4) item.force_restart = 1'b1;
          if (roll < 10)
            item.now_ms = clock_ms + $urandom_range(0, 32'(frame_gap));
          else if (roll < 13 || (rough_maze && roll < 25))
            item.now_ms = $urandom;
          else
            item.now_ms = clock_ms + 32'(frame_gap) + $urandom_range(0, 7);
        end
        maybe_pause();
        offer_item(item, 1'b0, '0);
        random_count++;
      end
    end
    steady = 1'b0;

    drain_and_rest();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmc_pkg.sv
rtl/backtracking_maze_carver.sv
sim/backtracking_maze_carver_test.sv
